// ===== src/dtq_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dtq_pkg: shared types for the deadline timer queue
// Transfer structs, status and opcode codes, per-cell key type.
// ---------------------------------------------------------------------------
package dtq_pkg;

  localparam int TIME_W  = 48;
  localparam int DELAY_W = 40;
  localparam int ID_W    = 32;
  localparam int MAX_RESULTS = 32;

  typedef enum logic [1:0] {
    OP_SUBMIT   = 2'd0,
    OP_CANCEL   = 2'd1,
    OP_TICK     = 2'd2,
    OP_SHUTDOWN = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_ACCEPTED    = 3'd0,
    ST_REJECTED    = 3'd1,
    ST_CANCELLED   = 3'd2,
    ST_CANCEL_FAIL = 3'd3,
    ST_FIRED       = 3'd4,
    ST_SHUT_CANCEL = 3'd5,
    ST_NONE        = 3'd6
  } status_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [TIME_W-1:0]  now_time;
    logic [DELAY_W-1:0] delay;
    logic [ID_W-1:0]    task_id;
  } cmd_t;

  typedef struct packed {
    logic [2:0]      status;
    logic [ID_W-1:0] result_id;
    logic            last;
  } rsp_t;

  // key handed along the chain of cells during a minimum sweep
  typedef struct packed {
    logic              vld;
    logic [TIME_W-1:0] deadline;
    logic [ID_W-1:0]   id;
  } key_t;

  // compare strobes broadcast from the sequencer to every cell
  typedef struct packed {
    logic              sweep;     // fold this cell into the running minimum
    logic              only_due;  // ignore entries later than now
    logic [TIME_W-1:0] now_time;
    logic              match;     // cancel compare on id
    logic [ID_W-1:0]   task_id;
    logic              pick;      // locate the entry that won the last sweep
    logic [TIME_W-1:0] pick_deadline;
    logic [ID_W-1:0]   pick_id;
  } cell_ctl_t;

endpackage

// ===== src/dtq_cell.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dtq_cell: one queue slot
// Holds one entry and folds it into the running minimum handed in from the
// previous cell, registering the smaller key toward the next cell; also
// compares ids for cancel and the full key to find the sweep winner.
// ---------------------------------------------------------------------------
module dtq_cell
  import dtq_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cell_ctl_t         ctl,
  input  key_t              key_in,
  output key_t              key_out,
  output logic              picked,    // valid and equal to the sweep winner
  output logic              hit,       // valid and id matches
  output logic              valid,
  input  logic              wr,
  input  logic [TIME_W-1:0] wr_deadline,
  input  logic [ID_W-1:0]   wr_id,
  input  logic              clr,
  output logic [ID_W-1:0]   id
);

  logic [TIME_W-1:0] deadline;
  logic              eligible;
  logic              win;
  key_t              key_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (wr) begin
      valid <= 1'b1;
    end else if (clr) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      deadline <= wr_deadline;
      id       <= wr_id;
    end
  end

  // strict less-than keeps the lower slot on equal keys
  assign eligible = valid && ctl.sweep && !(ctl.only_due && deadline > ctl.now_time);
  assign win = eligible && (!key_in.vld || deadline < key_in.deadline ||
               (deadline == key_in.deadline && id < key_in.id));

  always_ff @(posedge clk) begin
    if (rst) begin
      key_q <= '0;
    end else begin
      key_q <= win ? '{vld: 1'b1, deadline: deadline, id: id} : key_in;
    end
  end

  assign key_out = key_q;
  assign hit = valid && ctl.match && (id == ctl.task_id);
  assign picked = valid && ctl.pick && (deadline == ctl.pick_deadline) &&
                  (id == ctl.pick_id);

endmodule

// ===== src/deadline_timer_queue.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// deadline_timer_queue: deadline-ordered timer queue with cancel
// Submit, cancel, tick expiry and shutdown over a row of slot cells.
// ---------------------------------------------------------------------------
// channel | direction | handshake          | payload
// cmd     | in        | start & !busy      | cmd_t (opcode, now, delay, id)
// rsp     | out       | rsp_valid, 1 cycle | rsp_t (status, result_id, last)
//
// Steps: submit and cancel accept, then give the result; so do
// a tick or shutdown once the queue is shut down.
// Otherwise tick and shutdown run one sweep per reported entry plus a final
// one: the running minimum moves one cell per cycle, and each sweep is
// followed by its emit step.
// Reset clears every valid bit at once; no clearing pass.
// The receiver cannot stall; each result is emitted once the next sweep shows whether it is last.
// ---------------------------------------------------------------------------
module deadline_timer_queue
  import dtq_pkg::*;
#(
  parameter int CAPACITY = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  cmd_t cmd,
  output logic busy,
  output logic rsp_valid,
  output rsp_t rsp
);

  localparam int SW = $clog2(CAPACITY);
  localparam int CW = $clog2(MAX_RESULTS + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_EXEC  = 4'b0010,
    S_SWEEP = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  state_t          state;
  cmd_t            cur;
  logic [ID_W-1:0] next_id;
  logic            shut_down;
  logic [CW-1:0]   count;
  logic [SW:0]     sweep_cnt;
  logic [ID_W-1:0] hold_id;

  cell_ctl_t         ctl;
  key_t              chain [CAPACITY+1];
  logic [CAPACITY-1:0] picked, hit, valid, wr, clr;
  logic [ID_W-1:0]   ids [CAPACITY];
  logic [TIME_W-1:0] new_deadline;
  logic [TIME_W:0]   sum;

  // registered minimum of the last sweep
  logic              min_vld;
  logic [ID_W-1:0]   min_id;
  logic [TIME_W-1:0] min_deadline;

  logic [CAPACITY-1:0] free_first, hit_first, pick_first;

  assign busy = (state != S_IDLE);

  // control broadcast to the cells
  always_comb begin
    ctl.sweep         = (state == S_SWEEP);
    ctl.only_due      = (cur.opcode == OP_TICK);
    ctl.now_time      = cur.now_time;
    ctl.match         = (state == S_EXEC) && (cur.opcode == OP_CANCEL);
    ctl.task_id       = cur.task_id;
    ctl.pick          = (state == S_EMIT) && min_vld;
    ctl.pick_deadline = min_deadline;
    ctl.pick_id       = min_id;
  end

  assign chain[0] = '0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    dtq_cell u_cell (
      .clk(clk), .rst(rst), .ctl(ctl),
      .key_in(chain[g]), .key_out(chain[g+1]),
      .picked(picked[g]), .hit(hit[g]), .valid(valid[g]),
      .wr(wr[g]), .wr_deadline(new_deadline), .wr_id(next_id),
      .clr(clr[g]), .id(ids[g])
    );
  end

  // lowest free slot, lowest matching slot and lowest winner, as one-hot
  assign free_first = ~valid & (valid + 1'b1);
  assign hit_first  = hit & (~hit + 1'b1);
  assign pick_first = picked & (~picked + 1'b1);

  assign sum = {1'b0, cur.now_time} + {{(TIME_W-DELAY_W+1){1'b0}}, cur.delay};
  assign new_deadline = sum[TIME_W] ? '1 : sum[TIME_W-1:0];

  logic do_submit;
  assign do_submit = (state == S_EXEC) && (cur.opcode == OP_SUBMIT) && !shut_down
                     && (valid != '1);
  assign wr = do_submit ? free_first : '0;

  // drop the cancelled or reported entry; a shutdown drops everything when it ends
  always_comb begin
    clr = '0;
    if (state == S_EXEC && cur.opcode == OP_CANCEL) clr = hit_first;
    if (state == S_EMIT) begin
      if (min_vld && count != CW'(MAX_RESULTS)) clr = pick_first;
      else if (cur.opcode == OP_SHUTDOWN) clr = '1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      next_id   <= '0;
      shut_down <= 1'b0;
      rsp_valid <= 1'b0;
      count     <= '0;
      sweep_cnt <= '0;
      min_vld   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          rsp_valid <= 1'b0;
          if (start) begin
            cur   <= cmd;
            count <= '0;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          rsp.last <= 1'b1;
          case (cur.opcode)
            OP_SUBMIT: begin
              rsp_valid <= 1'b1;
              state     <= S_IDLE;
              if (do_submit) begin
                rsp.status    <= ST_ACCEPTED;
                rsp.result_id <= next_id;
                next_id       <= next_id + 1'b1;
              end else begin
                rsp.status    <= ST_REJECTED;
                rsp.result_id <= '0;
              end
            end
            OP_CANCEL: begin
              rsp_valid <= 1'b1;
              state     <= S_IDLE;
              if (hit != '0 && !shut_down) begin
                rsp.status    <= ST_CANCELLED;
                rsp.result_id <= cur.task_id;
              end else begin
                rsp.status    <= ST_CANCEL_FAIL;
                rsp.result_id <= '0;
              end
            end
            default: begin
              if (shut_down) begin
                rsp_valid     <= 1'b1;
                rsp.status    <= ST_NONE;
                rsp.result_id <= '0;
                state         <= S_IDLE;
              end else begin
                rsp_valid <= 1'b0;
                if (cur.opcode == OP_SHUTDOWN) shut_down <= 1'b1;
                sweep_cnt <= '0;
                state     <= S_SWEEP;
              end
            end
          endcase
        end
        S_SWEEP: begin
          // wait until the key has passed the last cell
          rsp_valid <= 1'b0;
          if (sweep_cnt == (SW+1)'(CAPACITY)) begin
            min_vld      <= chain[CAPACITY].vld;
            min_id       <= chain[CAPACITY].id;
            min_deadline <= chain[CAPACITY].deadline;
            state        <= S_EMIT;
          end else begin
            sweep_cnt <= sweep_cnt + 1'b1;
          end
        end
        S_EMIT: begin
          // hold each entry until the next sweep proves whether it is last
          if (min_vld && count != CW'(MAX_RESULTS)) begin
            rsp_valid     <= (count != '0);
            rsp.status    <= (cur.opcode == OP_TICK) ? ST_FIRED : ST_SHUT_CANCEL;
            rsp.result_id <= hold_id;
            rsp.last      <= 1'b0;
            hold_id       <= min_id;
            count         <= count + 1'b1;
            sweep_cnt     <= '0;
            state         <= S_SWEEP;
          end else begin
            rsp_valid <= 1'b1;
            rsp.last  <= 1'b1;
            if (count == '0) begin
              rsp.status    <= ST_NONE;
              rsp.result_id <= '0;
            end else begin
              rsp.status    <= (cur.opcode == OP_TICK) ? ST_FIRED : ST_SHUT_CANCEL;
              rsp.result_id <= hold_id;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          rsp_valid <= 1'b0;
          state     <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/dtq_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dtq_checker: port-level checks for the deadline timer queue
// Watches the command and result ports over time.
// ---------------------------------------------------------------------------
module dtq_checker
  import dtq_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic rsp_valid,
  input rsp_t rsp
);

  // a transfer in always makes the block busy next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("accept did not raise busy");

  // the final result frees the command side
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.last |-> !busy) else $error("busy after last result");

  // no result while idle and not just finished
  a_no_stray: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> $past(busy)) else $error("result without work");

  // status codes stay within the defined set
  a_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.status <= ST_NONE) else $error("bad status");

endmodule

bind deadline_timer_queue dtq_checker u_dtq_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy),
  .rsp_valid(rsp_valid), .rsp(rsp)
);
